// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Action and error codes, shared structs for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;
  localparam logic [2:0] ACT_CMP = 3'd5;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZDEN = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;
  localparam logic [1:0] ERR_OVF  = 2'd3;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam int WIDE = 64;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } req_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  cmp_result;
    logic [1:0]  error_code;
  } res_t;

  // control to / status from the serial datapath units
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/rau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface rau_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rau_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul
// Shift-and-add multiplier, 32 x 32 unsigned, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  rau_pkg::unit_ctl_t    ctl,
  input  logic [31:0]           x,
  input  logic [31:0]           y,
  output rau_pkg::unit_sts_t    sts,
  output logic [63:0]           p
);
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;

  // done is a pulse in the cycle after the last bit, when p is final
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && busy && (cnt == 6'd31);
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand  <= {32'd0, x};
      mplier <= y;
      p      <= '0;
    end else if (busy) begin
      if (mplier[0]) p <= p + mcand;
      mcand  <= {mcand[62:0], 1'b0};
      mplier <= {1'b0, mplier[31:1]};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

// ===== rtl/rau_gcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd on 64-bit unsigned values; one subtract or shift per cycle.
// gcd(0, y) = y.
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::unit_ctl_t ctl,
  input  logic [63:0]        x,
  input  logic [63:0]        y,
  output rau_pkg::unit_sts_t sts,
  output logic [63:0]        g
);
  logic [63:0] u, v;
  logic [6:0]  sh;
  logic        busy, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && busy && (u == 64'd0 || v == 64'd0);
      if (ctl.start) busy <= 1'b1;
      else if (busy && (u == 64'd0 || v == 64'd0)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      u  <= x;
      v  <= y;
      sh <= '0;
    end else if (busy) begin
      if (u == 64'd0 || v == 64'd0) begin
        g <= (u | v) << sh[5:0];
      end else if (!u[0] && !v[0]) begin
        u  <= u >> 1;
        v  <= v >> 1;
        sh <= sh + 7'd1;
      end else if (!u[0]) u <= u >> 1;
      else if (!v[0]) v <= v >> 1;
      else if (u >= v) u <= (u - v) >> 1;
      else v <= (v - u) >> 1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

// ===== rtl/rau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, 64 / 64 unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::unit_ctl_t ctl,
  input  logic [63:0]        n,
  input  logic [63:0]        d,
  output rau_pkg::unit_sts_t sts,
  output logic [63:0]        q
);
  logic [64:0] rem;
  logic [64:0] trial;
  logic [63:0] dv;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;

  assign trial = {rem[63:0], q[63]} - {1'b0, dv};

  // done is a pulse in the cycle after the last bit, when q is final
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && busy && (cnt == 7'd63);
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      q   <= n;
      dv  <= d;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial;
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[63:0], q[63]};
        q   <= {q[62:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add/sub/mul/div/negate/compare of signed fractions, result in lowest terms.
// Requests with a zero denominator or zero divisor skip the gcd and divider;
// others run through the bit-serial multiplier, the binary gcd and the
// bit-serial divider. One request at a time: the next one can be taken
// in the cycle after the result is accepted.
// Reset (synchronous, rst high) returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int VALUE_BITS = 32
) (
  input logic clk,
  input logic rst,
  rau_if.sink   in_ch,
  rau_if.source out_ch
);
  localparam logic [63:0] LIM = 64'd1 << (VALUE_BITS - 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_CM1 = 5'd1,  S_CM2 = 5'd2,
                         S_DISP = 5'd3,  S_LG  = 5'd4,  S_LD1 = 5'd5,
                         S_LM  = 5'd6,   S_LD2 = 5'd7,  S_LD3 = 5'd8,
                         S_T1  = 5'd9,   S_T2  = 5'd10, S_PM1 = 5'd11,
                         S_PM2 = 5'd12,  S_RG  = 5'd13, S_RD1 = 5'd14,
                         S_RD2 = 5'd15,  S_FIN = 5'd16, S_OUT = 5'd17;

  logic [4:0] state;
  rau_pkg::req_t r;
  rau_pkg::res_t res;

  // shared unit operands
  logic [31:0] mx, my;
  logic [63:0] gx, gy, dn, dd;
  rau_pkg::unit_ctl_t mctl, gctl, dctl;
  rau_pkg::unit_sts_t msts, gsts, dsts;
  logic [63:0] mp, gg, dq;

  rau_mul u_mul (.clk, .rst, .ctl(mctl), .x(mx), .y(my), .sts(msts), .p(mp));
  rau_gcd u_gcd (.clk, .rst, .ctl(gctl), .x(gx), .y(gy), .sts(gsts), .g(gg));
  rau_div u_div (.clk, .rst, .ctl(dctl), .n(dn), .d(dd), .sts(dsts), .q(dq));

  logic        an_neg, bn_neg;
  logic [31:0] an_mag, bn_mag;
  logic [63:0] lprod, lcm, la, lb, mag, den, ta, tb, g;
  logic        neg, started;
  logic [1:0]  err;

  assign an_neg = r.a_num[31];
  assign bn_neg = r.b_num[31];
  assign an_mag = an_neg ? 32'(-r.a_num) : r.a_num;
  assign bn_mag = bn_neg ? 32'(-r.b_num) : r.b_num;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;

  // signed 64-bit from magnitude and sign
  function automatic logic [63:0] sgn(input logic [63:0] m, input logic s);
    sgn = s ? (64'd0 - m) : m;
  endfunction

  logic [63:0] sum;
  logic        sneg;
  logic [63:0] sa, sb;
  logic [63:0] lsgn, rsgn;
  logic        ovf;
  logic [31:0] fin_num;
  assign sa   = sgn(ta, an_neg);
  assign sb   = sgn(tb, bn_neg);
  assign sum  = (r.action == rau_pkg::ACT_ADD) ? sa + sb : sa - sb;
  assign sneg = sum[63];
  assign lsgn = sgn(lprod, an_neg);
  assign rsgn = sgn(mp, bn_neg);

  assign ovf = ((neg && mag != 64'd0) ? mag > LIM : mag > LIM - 64'd1) ||
               den > LIM - 64'd1;
  assign fin_num = (neg && mag != 64'd0) ? 32'(64'd0 - mag) : mag[31:0];

  always_comb begin
    mctl.start = 1'b0; gctl.start = 1'b0; dctl.start = 1'b0;
    mx = '0; my = '0; gx = '0; gy = '0; dn = '0; dd = '0;
    unique case (state)
      S_IDLE: begin mctl.start = in_ch.valid;
        mx = in_ch.data.a_num[31] ? 32'(-in_ch.data.a_num) : in_ch.data.a_num;
        my = {1'b0, in_ch.data.b_den}; end
      S_CM1: begin mctl.start = msts.done; mx = bn_mag; my = {1'b0, r.a_den}; end
      S_DISP: begin gctl.start = 1'b1; gx = {33'd0, r.a_den}; gy = {33'd0, r.b_den};
        mctl.start = (r.action == rau_pkg::ACT_MUL) || (r.action == rau_pkg::ACT_DIV);
        mx = an_mag;
        my = (r.action == rau_pkg::ACT_MUL) ? bn_mag : {1'b0, r.b_den}; end
      S_LG: begin dctl.start = gsts.done; dn = {33'd0, r.a_den}; dd = gg; end
      S_LD1: begin mctl.start = dsts.done; mx = dq[31:0]; my = {1'b0, r.b_den}; end
      S_LM: begin dctl.start = msts.done; dn = mp; dd = {33'd0, r.b_den}; end
      S_LD2: begin dctl.start = dsts.done; dn = lcm; dd = {33'd0, r.a_den}; end
      S_LD3: begin mctl.start = dsts.done; mx = bn_mag; my = lb[31:0]; end
      S_T1: begin mctl.start = msts.done; mx = an_mag; my = la[31:0]; end
      S_PM1: begin mctl.start = msts.done; mx = {1'b0, r.a_den};
        my = (r.action == rau_pkg::ACT_MUL) ? {1'b0, r.b_den} : bn_mag; end
      S_RG: begin gctl.start = 1'b1; gx = mag; gy = den; end
      S_RD1: begin dctl.start = gsts.done; dn = mag; dd = gg; end
      S_RD2: begin dctl.start = dsts.done && !started; dn = den; dd = g; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin r <= in_ch.data; state <= S_CM1; end
        S_CM1: if (msts.done) begin lprod <= mp; state <= S_CM2; end
        S_CM2: if (msts.done) begin
          res.cmp_result <= (r.a_den == 0 || r.b_den == 0) ? rau_pkg::CMP_LT :
                            ($signed(lsgn) < $signed(rsgn)) ? rau_pkg::CMP_LT :
                            (lsgn == rsgn) ? rau_pkg::CMP_EQ : rau_pkg::CMP_GT;
          state <= S_DISP;
        end
        S_DISP: begin
          if (r.a_den == 0 || (r.b_den == 0 && r.action != rau_pkg::ACT_NEG)) begin
            err <= rau_pkg::ERR_ZDEN; state <= S_FIN;
          end else if (r.action == rau_pkg::ACT_DIV && r.b_num == 0) begin
            err <= rau_pkg::ERR_DIV0; state <= S_FIN;
          end else begin
            err <= rau_pkg::ERR_OK;
            unique case (r.action)
              rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: state <= S_LG;
              rau_pkg::ACT_MUL, rau_pkg::ACT_DIV: begin
                neg <= an_neg ^ bn_neg; state <= S_PM1; end
              rau_pkg::ACT_NEG: begin
                mag <= {32'd0, an_mag}; den <= {33'd0, r.a_den}; neg <= !an_neg;
                state <= S_RG; end
              default: begin mag <= '0; den <= 64'd1; neg <= 1'b0; state <= S_RG; end
            endcase
          end
        end
        S_LG: if (gsts.done) state <= S_LD1;
        S_LD1: if (dsts.done) state <= S_LM;
        S_LM: if (msts.done) begin lcm <= mp; state <= S_LD2; end
        S_LD2: if (dsts.done) begin lb <= dq; state <= S_LD3; end
        S_LD3: if (dsts.done) begin la <= dq; state <= S_T1; end
        S_T1: if (msts.done) begin tb <= mp; state <= S_T2; end
        S_T2: if (msts.done) begin ta <= mp; started <= 1'b1; end
          else if (started) begin
            started <= 1'b0;
            neg <= sneg; mag <= sneg ? 64'd0 - sum : sum; den <= lcm;
            state <= S_RG;
          end
        S_PM1: if (msts.done) begin mag <= mp; state <= S_PM2; end
        S_PM2: if (msts.done) begin den <= mp; state <= S_RG; end
        S_RG: state <= S_RD1;
        S_RD1: if (gsts.done) begin g <= gg; state <= S_RD2; end
        // numerator quotient first, then the denominator one
        S_RD2: if (dsts.done) begin
          if (!started) begin
            mag <= dq; started <= 1'b1;
          end else begin
            den <= dq; started <= 1'b0; state <= S_FIN;
          end
        end
        S_FIN: begin
          if (err == rau_pkg::ERR_OK && !ovf) begin
            res.res_num <= fin_num; res.res_den <= den[30:0];
            res.error_code <= rau_pkg::ERR_OK;
          end else begin
            res.res_num <= '0; res.res_den <= '0;
            res.error_code <= (err == rau_pkg::ERR_OK) ? rau_pkg::ERR_OVF : err;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/rau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rau_pkg::res_t res
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.error_code != rau_pkg::ERR_OK) |->
    (res.res_num == 0 && res.res_den == 0)) else $error("error result nonzero");
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.error_code == rau_pkg::ERR_OK) |-> res.res_den != 0)
    else $error("zero denominator on good result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res)))
    else $error("result dropped");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res(out_ch.data));

// ===== verif/rational_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// Watches the request and result channels of the rational arithmetic unit,
// computes the expected reduced fraction, compare code and error for every
// accepted request, and compares each result in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  rau_if.sink  req_mon,
  rau_if.sink  res_mon,
  output int   fail_count,
  output int   pending
);
  import rau_pkg::*;

  res_t expected_q[$];

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    mag_of = v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    gcd_of = x;
  endfunction

  function automatic res_t fraction_result(input req_t r);
    res_t o;
    logic signed [63:0] an, bn, lhs, rhs, s;
    logic [63:0] ad, bd, g, lcm, mag, den, lim;
    logic neg;
    an = {{32{r.a_num[31]}}, r.a_num};
    bn = {{32{r.b_num[31]}}, r.b_num};
    ad = {33'd0, r.a_den};
    bd = {33'd0, r.b_den};
    o = '0;
    mag = 0;
    den = 1;
    neg = 1'b0;
    if (ad != 0 && bd != 0) begin
      lhs = an * $signed(bd);
      rhs = bn * $signed(ad);
      o.cmp_result = lhs < rhs ? CMP_LT : (lhs == rhs ? CMP_EQ : CMP_GT);
    end
    if (ad == 0 || (bd == 0 && r.action != ACT_NEG)) begin
      o.error_code = ERR_ZDEN;
    end else if (r.action == ACT_ADD || r.action == ACT_SUB) begin
      g = gcd_of(ad, bd);
      lcm = ad / g * bd;
      s = an * $signed(lcm / ad);
      if (r.action == ACT_ADD) s = s + bn * $signed(lcm / bd);
      else s = s - bn * $signed(lcm / bd);
      neg = s < 0;
      mag = mag_of(s);
      den = lcm;
    end else if (r.action == ACT_MUL) begin
      mag = mag_of(an) * mag_of(bn);
      neg = (an < 0) != (bn < 0);
      den = ad * bd;
    end else if (r.action == ACT_DIV) begin
      if (bn == 0) begin
        o.error_code = ERR_DIV0;
      end else begin
        mag = mag_of(an) * bd;
        den = ad * mag_of(bn);
        neg = (an < 0) != (bn < 0);
      end
    end else if (r.action == ACT_NEG) begin
      mag = mag_of(an);
      neg = !(an < 0);
      den = ad;
    end
    if (o.error_code == ERR_OK) begin
      g = gcd_of(mag, den);
      lim = 64'd1 << (VALUE_BITS - 1);
      mag = mag / g;
      den = den / g;
      if (mag == 0) neg = 1'b0;
      if ((neg ? mag > lim : mag > lim - 1) || den > lim - 1) begin
        o.error_code = ERR_OVF;
      end else begin
        o.res_num = neg ? -mag[31:0] : mag[31:0];
        o.res_den = den[30:0];
      end
    end
    fraction_result = o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(fraction_result(req_mon.data));
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", res_mon.data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== res_mon.data) begin
            if (fail_count < 10)
              $display("mismatch: exp num %0d den %0d cmp %0d err %0d, got %0d %0d %0d %0d",
                       $signed(want.res_num), want.res_den, want.cmp_result,
                       want.error_code, $signed(res_mon.data.res_num),
                       res_mon.data.res_den, res_mon.data.cmp_result,
                       res_mon.data.error_code);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/rational_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Drives directed corner requests and random fractions into the unit with
// bursty sending and a stalling receiver; the checker scores every result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int RANDOM_REQS = 1330;
  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending;
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rau_if #(req_t) req_ch (clk);
  rau_if #(res_t) res_ch (clk);

  rational_arithmetic_unit u_top (
    .clk(clk), .rst(rst), .in_ch(req_ch.sink), .out_ch(res_ch.source)
  );

  rational_arithmetic_unit_checker u_checker (
    .clk(clk), .rst(rst), .req_mon(req_ch.sink), .res_mon(res_ch.sink),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // receiver stall pattern: alternate free-running and choppy stretches
  always @(posedge clk) begin
    int mode_left;
    int mode;
    if (rst) begin
      res_ch.ready <= 1'b0;
      mode_left = 0;
      mode = 0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 5))
      0: pick_num = $urandom_range(0, 20) - 10;
      1: pick_num = 32'h8000_0000 + $urandom_range(0, 3);
      2: pick_num = 32'h7fff_ffff - $urandom_range(0, 3);
      3: pick_num = 32'd0;
      default: pick_num = $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 5))
      0: pick_den = 31'($urandom_range(1, 24));
      1: pick_den = 31'(32'h7fff_ffff - $urandom_range(0, 3));
      2: pick_den = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'd1;
      3: pick_den = 31'($urandom_range(1, 1000) * 6);
      default: pick_den = 31'($urandom);
    endcase
  endfunction

  // one request, held until accepted; valid stays up for the next one
  task automatic send_req(input req_t r);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // valid drops only where a gap follows
  task automatic send_list(input req_t list[$]);
    int burst;
    burst = 0;
    foreach (list[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
      end
      burst--;
      send_req(list[i]);
    end
  endtask

  initial begin
    req_t reqs[$];
    req_t r;
    int wait_cycles;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    reqs.push_back('{ACT_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3});
    reqs.push_back('{ACT_SUB, 32'sd6, 31'd4, 32'sd3, 31'd2});
    reqs.push_back('{ACT_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1});
    reqs.push_back('{ACT_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1});
    reqs.push_back('{ACT_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3});
    reqs.push_back('{ACT_DIV, 32'sd4, 31'd6, 32'hffff_fffe, 31'd9});
    reqs.push_back('{ACT_NEG, 32'h8000_0000, 31'd1, 32'sd0, 31'd0});
    reqs.push_back('{ACT_NEG, 32'h8000_0000, 31'd2, 32'sd0, 31'd0});
    reqs.push_back('{ACT_NEG, 32'sd0, 31'd5, 32'sd3, 31'd4});
    reqs.push_back('{ACT_CMP, 32'sd2, 31'd4, 32'sd1, 31'd2});
    reqs.push_back('{3'd6, 32'hffff_ffff, 31'd3, 32'sd1, 31'd3});
    reqs.push_back('{3'd7, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff});
    reqs.push_back('{ACT_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1});
    reqs.push_back('{ACT_DIV, 32'sd1, 31'd1, 32'sd0, 31'd0});
    reqs.push_back('{ACT_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1});
    reqs.push_back('{ACT_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1});
    reqs.push_back('{ACT_ADD, 32'sd1, 31'h7fff_ffff, 32'sd1, 31'h7fff_fffe});
    reqs.push_back('{ACT_MUL, 32'sd0, 31'd7, 32'h8000_0000, 31'h7fff_ffff});
    reqs.push_back('{ACT_DIV, 32'sd0, 31'h7fff_ffff, 32'hffff_ffff, 31'd1});
    reqs.push_back('{ACT_SUB, 32'sd3, 31'd9, 32'sd1, 31'd3});
    reqs.push_back('{ACT_ADD, 32'hffff_ffff, 31'd1, 32'd1, 31'd1});
    send_list(reqs);

    reqs.delete();
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r.action = 3'($urandom_range(0, 7));
      r.a_num = pick_num();
      r.a_den = pick_den();
      r.b_num = pick_num();
      r.b_den = pick_den();
      reqs.push_back(r);
    end
    send_list(reqs);
    req_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (800) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_mul.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/rational_arithmetic_unit_checker.sv
verif/rational_arithmetic_unit_test.sv
